### rtl/core/kmer_edit_distance_unit_defines.svh
// assertion macros for the k-mer edit distance unit
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef KMER_EDIT_DISTANCE_UNIT_DEFINES_SVH
`define KMER_EDIT_DISTANCE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define KED_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication, checked out of reset
`define KED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define KED_ASSERT_IMPL(lbl, ante, cons)
`define KED_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/core/ked_pkg.sv
// shared types, constants and helpers for the k-mer edit distance unit
// no dependencies
package ked_pkg;

  localparam int KMER_W    = 64;
  localparam int BASE_W    = 2;
  localparam int POS_W     = 5;
  localparam int LEN_W     = 6;
  localparam int DIST_W    = 6;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd1;

  localparam logic [LEN_W-1:0]  KMER_LENGTH_RST  = 6'd32;
  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 6'd2;

  typedef enum logic {
    ST_IDLE,
    ST_CELL
  } ked_state_t;

  // base at position pos, two bits per base, base 0 lowest
  function automatic logic [BASE_W-1:0] base_at(input logic [KMER_W-1:0] kmer,
                                               input logic [POS_W-1:0] pos);
    base_at = kmer[BASE_W*pos +: BASE_W];
  endfunction

endpackage

### rtl/core/kmer_edit_distance_unit.sv
// k-mer edit distance unit: top level, one dp cell per cycle
// depends on ked_pkg and kmer_edit_distance_unit_defines.svh
`include "kmer_edit_distance_unit_defines.svh"

// Computes the Levenshtein distance of two packed k-mers (two bits per base,
// base 0 lowest) by filling the dp table one cell per clock with a single
// min-of-three unit, row by row. A transaction is taken when start is high
// and busy is low; busy then stays high until the result is produced. After
// each row the diagonal cell is compared with max_distance and the block
// stops early with that value if it is larger. A full run walks the whole
// k-by-k table (k = kmer_length clamped to MAX_BASES), an early exit after
// row i only its first i rows; the result strobe out_valid is high in the first
// cycle with busy low again, and a new transaction may be started in that
// same cycle. With kmer_length 0 the result appears the cycle after start
// with busy never raised. The result is shown for exactly one cycle and
// cannot be stalled: the receiver must capture it when out_valid is high.
// The cell unit's single pass through the row buffer sets the
// one-cell-per-cycle pace.
// Configuration writes are always taken (cfg_ready high) and must only be
// issued while the unit is idle; unknown register indexes are ignored.
module kmer_edit_distance_unit #(
  parameter int MAX_BASES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input transaction
  input  logic                           start,
  output logic                           busy,
  input  logic [ked_pkg::KMER_W-1:0]     in_first_kmer,
  input  logic [ked_pkg::KMER_W-1:0]     in_second_kmer,
  // result
  output logic                           out_valid,
  output logic [ked_pkg::DIST_W-1:0]     out_distance,
  output logic                           out_within_limit,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ked_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ked_pkg::LEN_W-1:0]      cfg_data
);

  localparam int CNT_W = $clog2(MAX_BASES + 1);
  localparam int IDX_W = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;
  localparam int VAL_W = $clog2(MAX_BASES + 2);

  // configuration registers
  logic [ked_pkg::LEN_W-1:0]  cfg_len_r;
  logic [ked_pkg::DIST_W-1:0] cfg_dist_r;

  // sequencer and item registers
  ked_pkg::ked_state_t state_r, state_nxt;
  logic [ked_pkg::KMER_W-1:0] first_r, first_nxt;
  logic [ked_pkg::KMER_W-1:0] second_r, second_nxt;
  logic [CNT_W-1:0]           k_r, k_nxt;
  logic [ked_pkg::DIST_W-1:0] d_r, d_nxt;
  logic [CNT_W-1:0]           i_r, i_nxt;      // row, 1..k
  logic [CNT_W-1:0]           j_r, j_nxt;      // column, 1..k
  logic [VAL_W-1:0]           left_r, left_nxt;   // cur[j-1]
  logic [VAL_W-1:0]           diag_r, diag_nxt;   // prev[j-1]
  logic [VAL_W-1:0]           dcell_r, dcell_nxt; // cur[i] of this row

  // previous row, entry j-1 holds column j
  logic [VAL_W-1:0] row_r [MAX_BASES];

  // result registers
  logic                       out_valid_r, out_valid_nxt;
  logic [ked_pkg::DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic                       out_within_r, out_within_nxt;

  // cell unit signals
  logic                       accept;
  logic [CNT_W-1:0]           len_clamp;
  logic [IDX_W-1:0]           iidx;
  logic [IDX_W-1:0]           jidx;
  logic [ked_pkg::BASE_W-1:0] base_a;
  logic [ked_pkg::BASE_W-1:0] base_b;
  logic [VAL_W-1:0]           up_v;
  logic [VAL_W-1:0]           sub_v;
  logic [VAL_W-1:0]           del_v;
  logic [VAL_W-1:0]           ins_v;
  logic [VAL_W-1:0]           min_a;
  logic [VAL_W-1:0]           cell_v;
  logic [VAL_W-1:0]           diag_val;
  logic [VAL_W-1:0]           result_v;
  logic                       row_end;
  logic                       last_row;
  logic                       early;
  logic                       finish;

  assign busy      = (state_r != ked_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_distance     = out_dist_r;
  assign out_within_limit = out_within_r;

  // lengths above the table size run as a full-size table
  assign len_clamp = (cfg_len_r > ked_pkg::LEN_W'(MAX_BASES)) ?
                     CNT_W'(MAX_BASES) : CNT_W'(cfg_len_r);

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r  <= ked_pkg::KMER_LENGTH_RST;
      cfg_dist_r <= ked_pkg::MAX_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ked_pkg::REG_KMER_LENGTH:  cfg_len_r  <= cfg_data;
        ked_pkg::REG_MAX_DISTANCE: cfg_dist_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // cell unit: D[i][j] = min(D[i-1][j-1] + (a != b), D[i-1][j] + 1,
  // D[i][j-1] + 1); the first row reads D[0][j] = j without the buffer
  // ---------------------------------------------------------------------
  assign iidx   = IDX_W'(i_r - CNT_W'(1));
  assign jidx   = IDX_W'(j_r - CNT_W'(1));
  assign base_a = ked_pkg::base_at(first_r, ked_pkg::POS_W'(iidx));
  assign base_b = ked_pkg::base_at(second_r, ked_pkg::POS_W'(jidx));

  assign up_v  = (i_r == CNT_W'(1)) ? VAL_W'(j_r) : row_r[jidx];
  assign sub_v = diag_r + VAL_W'(base_a != base_b);
  assign del_v = up_v + VAL_W'(1);
  assign ins_v = left_r + VAL_W'(1);
  assign min_a  = (del_v < sub_v) ? del_v : sub_v;
  assign cell_v = (ins_v < min_a) ? ins_v : min_a;

  // diagonal cell of the current row, this cycle's cell when on it
  assign diag_val = (j_r == i_r) ? cell_v : dcell_r;
  assign row_end  = (j_r == k_r);
  assign last_row = (i_r == k_r);
  assign early    = ked_pkg::DIST_W'(diag_val) > d_r;
  assign finish   = (state_r == ked_pkg::ST_CELL) && row_end && (early || last_row);
  assign result_v = early ? diag_val : cell_v;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ked_pkg::ST_IDLE: begin
        if (accept && (len_clamp != '0)) begin
          state_nxt = ked_pkg::ST_CELL;
        end
      end
      ked_pkg::ST_CELL: begin
        if (finish) begin
          state_nxt = ked_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ked_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    first_nxt      = first_r;
    second_nxt     = second_r;
    k_nxt          = k_r;
    d_nxt          = d_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    left_nxt       = left_r;
    diag_nxt       = diag_r;
    dcell_nxt      = dcell_r;
    out_valid_nxt  = 1'b0;
    out_dist_nxt   = out_dist_r;
    out_within_nxt = out_within_r;
    unique case (state_r)
      ked_pkg::ST_IDLE: begin
        if (accept) begin
          first_nxt  = in_first_kmer;
          second_nxt = in_second_kmer;
          k_nxt      = len_clamp;
          d_nxt      = cfg_dist_r;
          i_nxt      = CNT_W'(1);
          j_nxt      = CNT_W'(1);
          left_nxt   = VAL_W'(1);   // D[1][0]
          diag_nxt   = '0;          // D[0][0]
          // empty k-mers: table is just D[0][0]
          if (len_clamp == '0) begin
            out_valid_nxt  = 1'b1;
            out_dist_nxt   = '0;
            out_within_nxt = 1'b1;
          end
        end
      end
      ked_pkg::ST_CELL: begin
        if (j_r == i_r) begin
          dcell_nxt = cell_v;
        end
        if (!row_end) begin
          j_nxt    = j_r + CNT_W'(1);
          diag_nxt = up_v;
          left_nxt = cell_v;
        end else if (finish) begin
          out_valid_nxt  = 1'b1;
          out_dist_nxt   = ked_pkg::DIST_W'(result_v);
          out_within_nxt = ked_pkg::DIST_W'(result_v) <= d_r;
        end else begin
          // next row starts at D[i+1][0] = i+1 with D[i][0] = i on the diagonal
          i_nxt    = i_r + CNT_W'(1);
          j_nxt    = CNT_W'(1);
          diag_nxt = VAL_W'(i_r);
          left_nxt = VAL_W'(i_r) + VAL_W'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ked_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    first_r      <= first_nxt;
    second_r     <= second_nxt;
    k_r          <= k_nxt;
    d_r          <= d_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    left_r       <= left_nxt;
    diag_r       <= diag_nxt;
    dcell_r      <= dcell_nxt;
    out_dist_r   <= out_dist_nxt;
    out_within_r <= out_within_nxt;
  end

  // row buffer: each cell overwrites the previous row's entry it just read
  always_ff @(posedge clk) begin
    if (state_r == ked_pkg::ST_CELL) begin
      row_r[jidx] <= cell_v;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // a result is only ever strobed once the sequencer has let go
  `KED_ASSERT_IMPL(a_result_when_idle, out_valid_r, state_r == ked_pkg::ST_IDLE)

  // cell walk stays inside the table
  `KED_ASSERT_IMPL(a_cell_in_table, state_r == ked_pkg::ST_CELL,
                   (j_r != '0) && (i_r != '0) && (j_r <= k_r) && (i_r <= k_r))

  // a non-empty transaction always starts the cell walk
  `KED_ASSERT_NEXT(a_start_walks, accept && (len_clamp != '0),
                   state_r == ked_pkg::ST_CELL)

  // the limit flag agrees with the reported distance
  `KED_ASSERT_IMPL(a_flag_matches, out_valid_r, out_within_r == (out_dist_r <= d_r))

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for kmer_edit_distance_unit: directed and random k-mer pairs
// depends on ked_pkg and the kmer_edit_distance_unit rtl
module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 8000;  // well above a full 32-base run
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned NUM_PHASES     = 16;
  localparam int unsigned TABLE_MAX      = 32;    // bases the table is clamped to

  // indexes with no register behind them, written to check they are ignored
  localparam logic [ked_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [ked_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // base patterns: A=0 C=1 G=2 T=3 in every base
  localparam logic [ked_pkg::KMER_W-1:0] ALL_A = 64'h0000_0000_0000_0000;
  localparam logic [ked_pkg::KMER_W-1:0] ALL_C = 64'h5555_5555_5555_5555;
  localparam logic [ked_pkg::KMER_W-1:0] ALL_G = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [ked_pkg::KMER_W-1:0] ALL_T = 64'hFFFF_FFFF_FFFF_FFFF;

  // one queued driver action: either a k-mer pair or a register write
  typedef struct {
    bit                            is_write;
    logic [ked_pkg::CFG_IDX_W-1:0] reg_index;
    logic [ked_pkg::LEN_W-1:0]     reg_data;
    logic [ked_pkg::KMER_W-1:0]    first_kmer;
    logic [ked_pkg::KMER_W-1:0]    second_kmer;
    int unsigned                   gap;
  } kmer_op_t;

  typedef struct {
    logic [ked_pkg::DIST_W-1:0] distance;
    logic                       within_limit;
  } dist_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [ked_pkg::KMER_W-1:0]    in_first_kmer = '0;
  logic [ked_pkg::KMER_W-1:0]    in_second_kmer = '0;
  logic                          out_valid;
  logic [ked_pkg::DIST_W-1:0]    out_distance;
  logic                          out_within_limit;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ked_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ked_pkg::LEN_W-1:0]     cfg_data = '0;

  kmer_op_t     pending_ops[$];
  dist_result_t expected_distances[$];

  // shadow copies of the two registers, updated when a write transaction lands
  logic [ked_pkg::LEN_W-1:0]  kmer_len_shadow;
  logic [ked_pkg::DIST_W-1:0] dist_limit_shadow;

  int unsigned pairs_in_flight;
  int unsigned gap_left;
  int unsigned error_count = 0;

  int unsigned phase_len[NUM_PHASES];
  int unsigned phase_limit[NUM_PHASES];
  int unsigned phase_items[NUM_PHASES];

  kmer_edit_distance_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_first_kmer    (in_first_kmer),
    .in_second_kmer   (in_second_kmer),
    .out_valid        (out_valid),
    .out_distance     (out_distance),
    .out_within_limit (out_within_limit),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // levenshtein distance with the diagonal early exit, using the shadow registers
  function automatic dist_result_t edit_distance_of(
      input logic [ked_pkg::KMER_W-1:0] first_kmer,
      input logic [ked_pkg::KMER_W-1:0] second_kmer);
    int unsigned  prev_row[TABLE_MAX+1];
    int unsigned  this_row[TABLE_MAX+1];
    int unsigned  len, limit, run_dist, cand, i, j;
    bit           stopped;
    logic [1:0]   base_a, base_b;
    dist_result_t res;
    len = (kmer_len_shadow > TABLE_MAX) ? TABLE_MAX : kmer_len_shadow;
    limit = dist_limit_shadow;
    for (j = 0; j <= len; j++) prev_row[j] = j;
    this_row = prev_row;
    run_dist = prev_row[len];
    stopped = 1'b0;
    for (i = 1; i <= len && !stopped; i++) begin
      base_a = first_kmer[2*(i-1) +: 2];
      this_row[0] = i;
      for (j = 1; j <= len; j++) begin
        base_b = second_kmer[2*(j-1) +: 2];
        cand = prev_row[j-1] + ((base_a != base_b) ? 1 : 0);
        if (prev_row[j] + 1 < cand) cand = prev_row[j] + 1;
        if (this_row[j-1] + 1 < cand) cand = this_row[j-1] + 1;
        this_row[j] = cand;
      end
      prev_row = this_row;
      // diagonal above the limit ends the run with that value
      if (this_row[i] > limit) begin
        run_dist = this_row[i];
        stopped = 1'b1;
      end else begin
        run_dist = this_row[len];
      end
    end
    res.distance = run_dist[ked_pkg::DIST_W-1:0];
    res.within_limit = (run_dist <= limit);
    return res;
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // second k-mer derived from the first by a few random edits, high bits random
  function automatic logic [ked_pkg::KMER_W-1:0] near_kmer(
      input logic [ked_pkg::KMER_W-1:0] first_kmer,
      input int unsigned len,
      input int unsigned edits);
    logic [1:0]                 bases[$];
    logic [ked_pkg::KMER_W-1:0] second_kmer;
    int unsigned                e, pos, i;
    for (i = 0; i < len; i++) bases = {bases, first_kmer[2*i +: 2]};
    for (e = 0; e < edits && len > 0; e++) begin
      pos = $urandom_range(0, bases.size() - 1);
      case ($urandom_range(0, 2))
        0: bases[pos] = bases[pos] ^ 2'($urandom_range(1, 3));
        1: begin
          bases.insert(pos, 2'($urandom_range(0, 3)));
          void'(bases.pop_back());
        end
        default: begin
          bases.delete(pos);
          bases = {bases, 2'($urandom_range(0, 3))};
        end
      endcase
    end
    second_kmer = {$urandom, $urandom};
    for (i = 0; i < len; i++) second_kmer[2*i +: 2] = bases[i];
    return second_kmer;
  endfunction

  task automatic queue_write(input logic [ked_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ked_pkg::LEN_W-1:0] data);
    kmer_op_t op;
    op = '{is_write: 1'b1, reg_index: idx, reg_data: data, first_kmer: '0,
           second_kmer: '0, gap: $urandom_range(0, 2)};
    pending_ops = {pending_ops, op};
  endtask

  task automatic queue_pair(input logic [ked_pkg::KMER_W-1:0] first_kmer,
                            input logic [ked_pkg::KMER_W-1:0] second_kmer,
                            input int unsigned gap);
    kmer_op_t op;
    op = '{is_write: 1'b0, reg_index: '0, reg_data: '0, first_kmer: first_kmer,
           second_kmer: second_kmer, gap: gap};
    pending_ops = {pending_ops, op};
  endtask

  // random pair, biased toward similar k-mers so the whole table gets filled
  task automatic queue_random_pair(input int unsigned len_cfg, input int unsigned limit,
                                   input bit no_gaps);
    logic [ked_pkg::KMER_W-1:0] first_kmer, second_kmer;
    int unsigned                len, roll, reach;
    len = (len_cfg > TABLE_MAX) ? TABLE_MAX : len_cfg;
    reach = (limit > 6) ? 6 : limit;
    roll = $urandom_range(0, 99);
    first_kmer = {$urandom, $urandom};
    if (roll < 60) begin
      second_kmer = near_kmer(first_kmer, len, $urandom_range(0, reach + 2));
    end else if (roll < 75) begin
      second_kmer = {$urandom, $urandom};
    end else if (roll < 85) begin
      // same bases, only the unused high bits may differ
      second_kmer = near_kmer(first_kmer, len, 0);
    end else if (roll < 92) begin
      // single-base runs
      first_kmer = ALL_C * 64'($urandom_range(0, 3));
      second_kmer = near_kmer(first_kmer, len, $urandom_range(0, 3));
    end else begin
      first_kmer = ($urandom_range(0, 1) != 0) ? ALL_T : ALL_A;
      second_kmer = ($urandom_range(0, 1) != 0) ? ALL_T : ALL_A;
    end
    queue_pair(first_kmer, second_kmer, no_gaps ? 0 : pick_gap());
  endtask

  // driver: one pair or one register write at a time, writes only when idle
  always @(posedge clk) begin : driver
    logic     start_nxt;
    logic     cfg_valid_nxt;
    kmer_op_t op;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      kmer_len_shadow = ked_pkg::KMER_LENGTH_RST;
      dist_limit_shadow = ked_pkg::MAX_DISTANCE_RST;
      pairs_in_flight = 0;
      gap_left = 0;
    end else begin
      start_nxt = start;
      cfg_valid_nxt = cfg_valid;
      if (out_valid && pairs_in_flight > 0) pairs_in_flight--;
      // register write transaction lands
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ked_pkg::REG_KMER_LENGTH) kmer_len_shadow = cfg_data;
        else if (cfg_index == ked_pkg::REG_MAX_DISTANCE) dist_limit_shadow = cfg_data;
        cfg_valid_nxt = 1'b0;
      end
      // pair transaction accepted: predict its result now, under the current registers
      if (start && !busy) begin
        expected_distances = {expected_distances,
                              edit_distance_of(in_first_kmer, in_second_kmer)};
        pairs_in_flight++;
        start_nxt = 1'b0;
      end
      if (!start_nxt && !cfg_valid_nxt) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops[0];
          if (!op.is_write) begin
            void'(pending_ops.pop_front());
            in_first_kmer <= op.first_kmer;
            in_second_kmer <= op.second_kmer;
            start_nxt = 1'b1;
            gap_left = op.gap;
          end else if (pairs_in_flight == 0 && !busy) begin
            // every result is back, so the unit is idle
            void'(pending_ops.pop_front());
            cfg_index <= op.reg_index;
            cfg_data <= op.reg_data;
            cfg_valid_nxt = 1'b1;
            gap_left = op.gap;
          end
        end
      end
      start <= start_nxt;
      cfg_valid <= cfg_valid_nxt;
    end
  end

  // monitor: results come as one-cycle strobes, compared in order
  always @(posedge clk) begin : monitor
    dist_result_t want;
    if (rst_n && out_valid) begin
      if (expected_distances.size() == 0) begin
        $display("%0t: result with nothing expected: distance %0d within_limit %0b",
                 $time, out_distance, out_within_limit);
        error_count++;
      end else begin
        want = expected_distances.pop_front();
        if (out_distance !== want.distance) begin
          $display("%0t: distance mismatch: expected %0d, actual %0d",
                   $time, want.distance, out_distance);
          error_count++;
        end
        if (out_within_limit !== want.within_limit) begin
          $display("%0t: within_limit mismatch: expected %0b, actual %0b",
                   $time, want.within_limit, out_within_limit);
          error_count++;
        end
      end
    end
  end

  // watchdog: ends the run once nothing has moved for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("kmer_edit_distance_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [ked_pkg::KMER_W-1:0] pick;
    int unsigned                p, n;
    bit                         no_gaps;

    // directed pairs under the reset settings: 32 bases, limit 2
    queue_pair(ALL_A, ALL_A, pick_gap());
    queue_pair(ALL_T, ALL_T, pick_gap());
    queue_pair(ALL_A, ALL_T, pick_gap());           // early exit on the diagonal
    pick = {$urandom, $urandom};
    queue_pair(pick, pick ^ 64'h1, pick_gap());     // one substitution at base 0
    queue_pair(pick, {pick[ked_pkg::KMER_W-3:0], 2'b01}, pick_gap());  // base in front
    queue_pair(ALL_C, ALL_G, pick_gap());

    // zero length: only the corner cell exists
    queue_write(ked_pkg::REG_KMER_LENGTH, 6'd0);
    queue_pair(ALL_T, ALL_A, pick_gap());
    queue_pair({$urandom, $urandom}, {$urandom, $urandom}, pick_gap());

    // length above the bound is clamped, limit above the table size
    queue_write(ked_pkg::REG_KMER_LENGTH, 6'd63);
    queue_write(ked_pkg::REG_MAX_DISTANCE, 6'd63);
    queue_pair(ALL_A, ALL_T, pick_gap());
    queue_pair({$urandom, $urandom}, {$urandom, $urandom}, pick_gap());

    // single base, zero limit
    queue_write(ked_pkg::REG_KMER_LENGTH, 6'd1);
    queue_write(ked_pkg::REG_MAX_DISTANCE, 6'd0);
    queue_pair(ALL_A, ALL_A, pick_gap());
    queue_pair(ALL_A, 64'h3, pick_gap());
    queue_pair(64'hFFFF_FFFF_FFFF_FFFC, ALL_A, pick_gap());  // high bases ignored

    // three bases, garbage above them
    queue_write(ked_pkg::REG_KMER_LENGTH, 6'd3);
    queue_write(ked_pkg::REG_MAX_DISTANCE, 6'd1);
    queue_pair(ALL_A, 64'hFFFF_FFFF_FFFF_FFC0, pick_gap());
    queue_pair(64'h06, 64'h18, pick_gap());

    // full table, limit equal to its size
    queue_write(ked_pkg::REG_KMER_LENGTH, 6'd32);
    queue_write(ked_pkg::REG_MAX_DISTANCE, 6'd32);
    queue_pair(ALL_A, ALL_T, pick_gap());
    queue_pair(ALL_T, ALL_C, pick_gap());

    // unmapped indexes must not disturb the registers
    queue_write(REG_SPARE_2, 6'd5);
    queue_write(REG_SPARE_3, 6'd0);
    queue_pair({$urandom, $urandom}, {$urandom, $urandom}, pick_gap());

    queue_write(ked_pkg::REG_MAX_DISTANCE, 6'd0);
    pick = {$urandom, $urandom};
    queue_pair(pick, pick, pick_gap());
    queue_pair(pick, pick ^ (64'h1 << 20), pick_gap());

    // random phases, short k-mers get most of the items
    phase_len   = '{1, 2, 4, 8, 32, 16, 0, 63, 5, 12, 32, 3, 24, 7, 40, 6};
    phase_limit = '{0, 1, 2, 3, 2, 63, 5, 40, 0, 4, 32, 33, 8, 1, 6, 2};
    phase_items = '{120, 120, 150, 180, 120, 150, 60, 40, 120, 150, 40, 120, 80, 120,
                    60, 100};
    for (p = 0; p < NUM_PHASES; p++) begin
      no_gaps = (p % 4 == 2);
      queue_write(ked_pkg::REG_KMER_LENGTH, ked_pkg::LEN_W'(phase_len[p]));
      queue_write(ked_pkg::REG_MAX_DISTANCE, ked_pkg::DIST_W'(phase_limit[p]));
      for (n = 0; n < phase_items[p]; n++)
        queue_random_pair(phase_len[p], phase_limit[p], no_gaps);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // everything sent, then everything back, then a quiet tail
    while (pending_ops.size() > 0 || start || cfg_valid) @(posedge clk);
    while (expected_distances.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_distances.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, expected_distances.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("kmer_edit_distance_unit verification clean");
    end else begin
      $display("kmer_edit_distance_unit verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ked_pkg.sv
rtl/core/kmer_edit_distance_unit.sv
verif/tb_top.sv
